/* rtl/core/apc_pkg.sv */
// Shared types, constants and the control program of the asymmetric PID controller.
package apc_pkg;

    localparam int ERR_W      = 16;
    localparam int DT_W       = 16;
    localparam int DRIVE_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int SCALE_W    = 16;
    localparam int INTEG_W    = 48;
    localparam int EN_W       = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int SUM_W      = 50;
    localparam int SUM_LO_W   = 25;
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int RES_W      = 66;
    localparam int DIV_W      = 32;
    localparam int DIV_CNT_W  = 6;
    localparam int PC_W       = 4;

    // enables register bits
    localparam int EN_INT     = 0;
    localparam int EN_OUT_MIN = 1;
    localparam int EN_OUT_MAX = 2;
    localparam int EN_INT_MIN = 3;
    localparam int EN_INT_MAX = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAINS_POS = 3'd0,
        CFG_GAINS_NEG = 3'd1,
        CFG_SCALE     = 3'd2,
        CFG_OUT_MIN   = 3'd3,
        CFG_OUT_MAX   = 3'd4,
        CFG_INT_MIN   = 3'd5,
        CFG_INT_MAX   = 3'd6,
        CFG_ENABLES   = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_KP_E,
        MUL_KI_E,
        MUL_PROD_DT,
        MUL_KD_DIFF,
        MUL_SUM_LO,
        MUL_SUM_HI
    } mul_op_t;

    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_SUM_LOAD,
        ALU_INT_ADD,
        ALU_INT_CLAMP,
        ALU_SUM_INT,
        ALU_DIV_START,
        ALU_SUM_DIV,
        ALU_RES_LOAD,
        ALU_RES_HI,
        ALU_SAT,
        ALU_CLAMP,
        ALU_EMIT
    } alu_op_t;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_SKIP_NO_INT,
        COND_WAIT_DIV,
        COND_WAIT_OUT
    } seq_cond_t;

    typedef struct packed {
        mul_op_t         mul;
        alu_op_t         alu;
        seq_cond_t       cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    localparam logic [PC_W-1:0] ST_KP       = 4'd0;
    localparam logic [PC_W-1:0] ST_KI       = 4'd1;
    localparam logic [PC_W-1:0] ST_KI_DT    = 4'd2;
    localparam logic [PC_W-1:0] ST_INT_ADD  = 4'd3;
    localparam logic [PC_W-1:0] ST_INT_CLMP = 4'd4;
    localparam logic [PC_W-1:0] ST_SUM_INT  = 4'd5;
    localparam logic [PC_W-1:0] ST_KD       = 4'd6;
    localparam logic [PC_W-1:0] ST_DIV      = 4'd7;
    localparam logic [PC_W-1:0] ST_DIV_WAIT = 4'd8;
    localparam logic [PC_W-1:0] ST_SUM_DIV  = 4'd9;
    localparam logic [PC_W-1:0] ST_SCL_LO   = 4'd10;
    localparam logic [PC_W-1:0] ST_SCL_HI   = 4'd11;
    localparam logic [PC_W-1:0] ST_RES_HI   = 4'd12;
    localparam logic [PC_W-1:0] ST_SAT      = 4'd13;
    localparam logic [PC_W-1:0] ST_CLAMP    = 4'd14;
    localparam logic [PC_W-1:0] ST_EMIT     = 4'd15;

    // Control store: one word per step.
    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t cw;
        cw = '{mul: MUL_NONE, alu: ALU_NONE, cond: COND_NEXT, target: ST_KP};
        unique case (pc)
            ST_KP:       cw.mul = MUL_KP_E;
            ST_KI:       cw = '{mul: MUL_KI_E, alu: ALU_SUM_LOAD,
                                cond: COND_SKIP_NO_INT, target: ST_KD};
            ST_KI_DT:    cw.mul = MUL_PROD_DT;
            ST_INT_ADD:  cw.alu = ALU_INT_ADD;
            ST_INT_CLMP: cw.alu = ALU_INT_CLAMP;
            ST_SUM_INT:  cw.alu = ALU_SUM_INT;
            ST_KD:       cw.mul = MUL_KD_DIFF;
            ST_DIV:      cw.alu = ALU_DIV_START;
            ST_DIV_WAIT: cw.cond = COND_WAIT_DIV;
            ST_SUM_DIV:  cw.alu = ALU_SUM_DIV;
            ST_SCL_LO:   cw.mul = MUL_SUM_LO;
            ST_SCL_HI:   cw = '{mul: MUL_SUM_HI, alu: ALU_RES_LOAD,
                                cond: COND_NEXT, target: ST_KP};
            ST_RES_HI:   cw.alu = ALU_RES_HI;
            ST_SAT:      cw.alu = ALU_SAT;
            ST_CLAMP:    cw.alu = ALU_CLAMP;
            ST_EMIT:     cw = '{mul: MUL_NONE, alu: ALU_EMIT,
                                cond: COND_WAIT_OUT, target: ST_KP};
        endcase
        return cw;
    endfunction

endpackage

/* rtl/core/apc_if.sv */
// Command and result channel interfaces of the asymmetric PID controller.
interface apc_cmd_if;
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic signed [apc_pkg::ERR_W-1:0]    error_in;
    logic        [apc_pkg::DT_W-1:0]     step_ms;

    modport source (output valid, mode, error_in, step_ms, input ready);
    modport sink   (input valid, mode, error_in, step_ms, output ready);
endinterface

interface apc_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [apc_pkg::DRIVE_W-1:0]  drive;
    logic                                out_clamped;
    logic                                int_clamped;

    modport source (output valid, drive, out_clamped, int_clamped, input ready);
    modport sink   (input valid, drive, out_clamped, int_clamped, output ready);
endinterface

/* rtl/core/asymmetric_pid_controller_top.sv */
// Asymmetric PID controller: microcoded datapath, configuration registers, result register.
//
// Usage:
//   cmd carries one step (mode, error_in, step_ms); rsp returns one result
//   (drive, out_clamped, int_clamped) per command, in order. Both use
//   valid/ready; a transfer happens when both are high at a rising edge.
//   cfg_we/cfg_index/cfg_data write one configuration register per cycle and
//   must only be used while no command is in flight.
//   A control step runs a 16-step microprogram over one shared 34x17 multiplier
//   and a 1-bit-per-cycle restoring divider for the derivative. With integration
//   off the integral steps are skipped, and when step_ms is 0 the divider is
//   skipped. A clear command (mode 1) goes straight to the last step and
//   returns a zero result.
//   cmd.ready is high only while no command is in progress, so one command is
//   worked on at a time; the next one can be taken while a finished result is
//   still held in the output register.
//   If rsp.ready stays low, the result register holds and the program waits in
//   its last step; the following command is then not finished until it drains.
//   Reset (rst_n low, asynchronous) restores the configuration registers to their
//   defaults, clears the integral and previous error and empties the result register.
module asymmetric_pid_controller_top (
    input  logic                           clk,
    input  logic                           rst_n,
    apc_cmd_if.sink                        cmd,
    apc_rsp_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [apc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import apc_pkg::*;

    // configuration
    logic        [CFG_DATA_W-1:0] gains_pos_reg;
    logic        [CFG_DATA_W-1:0] gains_neg_reg;
    logic signed [SCALE_W-1:0]    scale_reg;
    logic signed [DRIVE_W-1:0]    out_min_reg;
    logic signed [DRIVE_W-1:0]    out_max_reg;
    logic signed [INTEG_W-1:0]    int_min_reg;
    logic signed [INTEG_W-1:0]    int_max_reg;
    logic        [EN_W-1:0]       enables_reg;

    // controller state
    logic signed [ERR_W-1:0]      prev_error_reg;
    logic                         have_prev_reg;
    logic signed [INTEG_W-1:0]    integ_reg;

    // working registers
    logic signed [ERR_W-1:0]      e_reg;
    logic        [DT_W-1:0]       dt_reg;
    logic signed [DIFF_W-1:0]     diff_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [INTEG_W:0]      s_reg;
    logic signed [RES_W-1:0]      res_reg;
    logic signed [DRIVE_W-1:0]    v_reg;
    logic                         oc_reg;
    logic                         ic_reg;

    // divider
    logic [DIV_W-1:0]             quo_reg;
    logic [DT_W-1:0]              rem_reg;
    logic [DIV_CNT_W-1:0]         div_cnt_reg;
    logic                         q_neg_reg;

    // sequencer
    logic                         busy_reg;
    logic                         busy_next;
    logic [PC_W-1:0]              pc_reg;
    logic [PC_W-1:0]              pc_next;

    // result register
    logic                         out_valid_reg;
    logic signed [DRIVE_W-1:0]    drive_reg;
    logic                         out_clamped_reg;
    logic                         int_clamped_reg;

    ctrl_word_t                   cw;
    logic                         cmd_xfer;
    logic                         out_free;
    logic                         int_on;
    logic                         div_busy;
    logic        [CFG_DATA_W-1:0] gain_sel;
    logic signed [GAIN_W-1:0]     kp;
    logic signed [GAIN_W-1:0]     ki;
    logic signed [GAIN_W-1:0]     kd;
    logic signed [GAIN_W-1:0]     ki_pos;
    logic signed [GAIN_W-1:0]     ki_neg;
    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]     mul_res;
    logic signed [INTEG_W-1:0]    int_sat;
    logic signed [INTEG_W-1:0]    int_lim;
    logic                         int_hit;
    logic [DIV_W:0]               div_mag;
    logic [DT_W:0]                div_trial;
    logic [DT_W:0]                div_dsr;
    logic                         div_ge;
    logic [DIV_W:0]               quo_signed;
    logic signed [DRIVE_W-1:0]    v_lim;
    logic                         v_hit;

    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign cmd.ready = !busy_reg;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign div_busy  = (div_cnt_reg != '0);
    assign cw        = ucode(pc_reg);

    assign rsp.valid       = out_valid_reg;
    assign rsp.drive       = drive_reg;
    assign rsp.out_clamped = out_clamped_reg;
    assign rsp.int_clamped = int_clamped_reg;

    // gain set follows the sign of the current error
    assign gain_sel = e_reg[ERR_W-1] ? gains_neg_reg : gains_pos_reg;
    assign kp       = gain_sel[GAIN_W-1:0];
    assign ki       = gain_sel[2*GAIN_W-1:GAIN_W];
    assign kd       = gain_sel[3*GAIN_W-1:2*GAIN_W];
    assign ki_pos   = gains_pos_reg[2*GAIN_W-1:GAIN_W];
    assign ki_neg   = gains_neg_reg[2*GAIN_W-1:GAIN_W];
    assign int_on   = enables_reg[EN_INT] && (ki_pos > 0) && (ki_neg > 0);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_pos_reg <= CFG_DATA_W'(256);
            gains_neg_reg <= CFG_DATA_W'(256);
            scale_reg     <= SCALE_W'(256);
            out_min_reg   <= {1'b1, {(DRIVE_W-1){1'b0}}};
            out_max_reg   <= {1'b0, {(DRIVE_W-1){1'b1}}};
            int_min_reg   <= {1'b1, {(INTEG_W-1){1'b0}}};
            int_max_reg   <= {1'b0, {(INTEG_W-1){1'b1}}};
            enables_reg   <= EN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_GAINS_POS: gains_pos_reg <= cfg_data;
                CFG_GAINS_NEG: gains_neg_reg <= cfg_data;
                CFG_SCALE:     scale_reg     <= cfg_data[SCALE_W-1:0];
                CFG_OUT_MIN:   out_min_reg   <= cfg_data[DRIVE_W-1:0];
                CFG_OUT_MAX:   out_max_reg   <= cfg_data[DRIVE_W-1:0];
                CFG_INT_MIN:   int_min_reg   <= cfg_data[INTEG_W-1:0];
                CFG_INT_MAX:   int_max_reg   <= cfg_data[INTEG_W-1:0];
                CFG_ENABLES:   enables_reg   <= cfg_data[EN_W-1:0];
            endcase
        end
    end

    // sequencer next step
    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            unique case (cw.cond)
                COND_NEXT:        pc_next = pc_reg + 1'b1;
                COND_SKIP_NO_INT: pc_next = int_on ? pc_reg + 1'b1 : cw.target;
                COND_WAIT_DIV:    pc_next = div_busy ? pc_reg : pc_reg + 1'b1;
                COND_WAIT_OUT:
                begin
                    if (out_free)
                    begin
                        busy_next = 1'b0;
                        pc_next   = cw.target;
                    end
                end
            endcase
        end
        else if (cmd_xfer)
        begin
            busy_next = 1'b1;
            pc_next   = cmd.mode ? ST_EMIT : ST_KP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= ST_KP;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cw.mul)
            MUL_NONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            MUL_KP_E:
            begin
                mul_a = {{(MUL_A_W-ERR_W){e_reg[ERR_W-1]}}, e_reg};
                mul_b = {kp[GAIN_W-1], kp};
            end
            MUL_KI_E:
            begin
                mul_a = {{(MUL_A_W-ERR_W){e_reg[ERR_W-1]}}, e_reg};
                mul_b = {ki[GAIN_W-1], ki};
            end
            MUL_PROD_DT:
            begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = {1'b0, dt_reg};
            end
            MUL_KD_DIFF:
            begin
                mul_a = {{(MUL_A_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
                mul_b = {kd[GAIN_W-1], kd};
            end
            MUL_SUM_LO:
            begin
                mul_a = {{(MUL_A_W-SUM_LO_W){1'b0}}, sum_reg[SUM_LO_W-1:0]};
                mul_b = {scale_reg[SCALE_W-1], scale_reg};
            end
            MUL_SUM_HI:
            begin
                mul_a = {{(MUL_A_W-SUM_W+SUM_LO_W){sum_reg[SUM_W-1]}},
                         sum_reg[SUM_W-1:SUM_LO_W]};
                mul_b = {scale_reg[SCALE_W-1], scale_reg};
            end
        endcase
    end

    assign mul_res = mul_a * mul_b;

    // integral: 48-bit saturation, then the optional limits (max first)
    always_comb
    begin
        if (s_reg[INTEG_W:INTEG_W-1] == 2'b01)
            int_sat = {1'b0, {(INTEG_W-1){1'b1}}};
        else if (s_reg[INTEG_W:INTEG_W-1] == 2'b10)
            int_sat = {1'b1, {(INTEG_W-1){1'b0}}};
        else
            int_sat = s_reg[INTEG_W-1:0];
        int_hit = (s_reg[INTEG_W] != s_reg[INTEG_W-1]);
        int_lim = int_sat;
        if (enables_reg[EN_INT_MAX] && (int_sat > int_max_reg))
        begin
            int_lim = int_max_reg;
            int_hit = 1'b1;
        end
        else if (enables_reg[EN_INT_MIN] && (int_sat < int_min_reg))
        begin
            int_lim = int_min_reg;
            int_hit = 1'b1;
        end
    end

    // output limits, max first
    always_comb
    begin
        v_lim = v_reg;
        v_hit = 1'b0;
        if (enables_reg[EN_OUT_MAX] && (v_reg > out_max_reg))
        begin
            v_lim = out_max_reg;
            v_hit = 1'b1;
        end
        else if (enables_reg[EN_OUT_MIN] && (v_reg < out_min_reg))
        begin
            v_lim = out_min_reg;
            v_hit = 1'b1;
        end
    end

    // divider magnitude and quotient sign
    assign div_mag    = prod_reg[PROD_W-1] ? ((DIV_W+1)'(0) - prod_reg[DIV_W:0])
                                           : prod_reg[DIV_W:0];
    assign div_dsr    = {1'b0, dt_reg};
    assign div_trial  = {rem_reg, quo_reg[DIV_W-1]};
    assign div_ge     = (div_trial >= div_dsr);
    assign quo_signed = q_neg_reg ? ((DIV_W+1)'(0) - {1'b0, quo_reg}) : {1'b0, quo_reg};

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (busy_reg && (cw.alu == ALU_DIV_START))
            div_cnt_reg <= (dt_reg != '0) ? DIV_CNT_W'(DIV_W) : '0;
        else if (div_busy)
            div_cnt_reg <= div_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && (cw.alu == ALU_DIV_START))
        begin
            quo_reg   <= (dt_reg != '0) ? div_mag[DIV_W-1:0] : '0;
            rem_reg   <= '0;
            q_neg_reg <= prod_reg[PROD_W-1];
        end
        else if (div_busy)
        begin
            rem_reg <= div_ge ? DT_W'(div_trial - div_dsr) : div_trial[DT_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], div_ge};
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg <= '0;
            have_prev_reg  <= 1'b0;
            integ_reg      <= '0;
        end
        else if (cmd_xfer)
        begin
            if (cmd.mode)
            begin
                prev_error_reg <= '0;
                integ_reg      <= '0;
            end
            else
            begin
                prev_error_reg <= cmd.error_in;
                have_prev_reg  <= 1'b1;
            end
        end
        else if (busy_reg && (cw.alu == ALU_INT_CLAMP))
            integ_reg <= int_lim;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            e_reg    <= cmd.error_in;
            dt_reg   <= cmd.step_ms;
            diff_reg <= have_prev_reg ? (DIFF_W'(cmd.error_in) - DIFF_W'(prev_error_reg))
                                      : '0;
            v_reg    <= '0;
            oc_reg   <= 1'b0;
            ic_reg   <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (cw.mul != MUL_NONE)
                prod_reg <= mul_res;
            unique case (cw.alu)
                ALU_NONE, ALU_DIV_START, ALU_EMIT:
                begin
                end
                ALU_SUM_LOAD:
                    sum_reg <= {{(SUM_W-DRIVE_W){prod_reg[DRIVE_W-1]}},
                                prod_reg[DRIVE_W-1:0]};
                ALU_INT_ADD:
                    s_reg <= {integ_reg[INTEG_W-1], integ_reg}
                           + {prod_reg[INTEG_W-1], prod_reg[INTEG_W-1:0]};
                ALU_INT_CLAMP:
                    ic_reg <= int_hit;
                ALU_SUM_INT:
                    sum_reg <= sum_reg + {{(SUM_W-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg};
                ALU_SUM_DIV:
                    sum_reg <= sum_reg + {{(SUM_W-DIV_W-1){quo_signed[DIV_W]}}, quo_signed};
                ALU_RES_LOAD:
                    res_reg <= {{(RES_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                ALU_RES_HI:
                    res_reg <= res_reg
                             + {prod_reg[RES_W-SUM_LO_W-1:0], {SUM_LO_W{1'b0}}};
                ALU_SAT:
                begin
                    // floor shift by 8, then saturate to 32 bits
                    if (res_reg[RES_W-1:DRIVE_W+7] == {(RES_W-DRIVE_W-7){res_reg[RES_W-1]}})
                        v_reg <= res_reg[DRIVE_W+7:8];
                    else
                    begin
                        v_reg  <= res_reg[RES_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                                                   : {1'b0, {(DRIVE_W-1){1'b1}}};
                        oc_reg <= 1'b1;
                    end
                end
                ALU_CLAMP:
                begin
                    v_reg <= v_lim;
                    if (v_hit)
                        oc_reg <= 1'b1;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (busy_reg && (cw.alu == ALU_EMIT) && out_free)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && (cw.alu == ALU_EMIT) && out_free)
        begin
            drive_reg       <= v_reg;
            out_clamped_reg <= oc_reg;
            int_clamped_reg <= ic_reg;
        end
    end

endmodule

/* rtl/core/apc_checker.sv */
// Port-level checks for the asymmetric PID controller and their bind to the top level.
module apc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cmd_valid,
    input logic                                cmd_ready,
    input logic                                cmd_mode,
    input logic                                rsp_valid,
    input logic                                rsp_ready,
    input logic signed [apc_pkg::DRIVE_W-1:0]  rsp_drive,
    input logic                                rsp_out_clamped,
    input logic                                rsp_int_clamped
);
    import apc_pkg::*;

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive))
        else $error("result changed while stalled");

    // one command in flight: no transfer in the cycle after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command accepted while busy");

    // a clear with an empty result register returns zeros with no clamp flags
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_mode && !rsp_valid |=> ##1
        (rsp_valid && (rsp_drive == '0) && !rsp_out_clamped && !rsp_int_clamped))
        else $error("clear command gave a wrong result");

endmodule

bind asymmetric_pid_controller_top apc_checker u_apc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .cmd_mode        (cmd.mode),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_drive       (rsp.drive),
    .rsp_out_clamped (rsp.out_clamped),
    .rsp_int_clamped (rsp.int_clamped)
);

/* test/asymmetric_pid_controller_top_tb.sv */
// Self-checking testbench for the asymmetric PID controller top level.
`timescale 1ns / 1ps

module asymmetric_pid_controller_top_tb;
    import apc_pkg::*;

    localparam int     STALL_LIMIT   = 1000;
    localparam int     TAIL_CYCLES   = 64;
    localparam int     RAND_PHASES   = 10;
    localparam int     PHASE_ITEMS   = 115;
    localparam longint INTEG_MAX_V   = (longint'(1) <<< 47) - 1;
    localparam longint INTEG_MIN_V   = -(longint'(1) <<< 47);
    localparam longint DRIVE_MAX_V   = 64'sd2147483647;
    localparam longint DRIVE_MIN_V   = -64'sd2147483648;

    // configuration styles for the random phases
    localparam int STYLE_TYPICAL = 0;
    localparam int STYLE_MAX     = 1;
    localparam int STYLE_MIN     = 2;
    localparam int STYLE_ANY     = 3;
    localparam int STYLE_NO_OUT  = 4;

    typedef struct {
        logic        [47:0] gains_pos;
        logic        [47:0] gains_neg;
        logic signed [15:0] scale;
        logic signed [31:0] out_min;
        logic signed [31:0] out_max;
        logic signed [47:0] int_min;
        logic signed [47:0] int_max;
        logic        [4:0]  enables;
    } ctl_cfg_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               out_clamped;
        logic               int_clamped;
    } step_result_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    apc_cmd_if cmd_ch();
    apc_rsp_if rsp_ch();

    asymmetric_pid_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // controller copy kept by the testbench
    ctl_cfg_t           cur_cfg;
    longint             integ_acc;
    logic signed [15:0] last_err;
    logic               have_last;

    step_result_t pending_drive[$];
    int           err_count;
    bit           gaps_on;
    int           stall_left;
    int           quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic ctl_cfg_t reset_cfg();
        ctl_cfg_t c;
        c.gains_pos = 48'd256;
        c.gains_neg = 48'd256;
        c.scale     = 16'sd256;
        c.out_min   = 32'sh80000000;
        c.out_max   = 32'sh7FFFFFFF;
        c.int_min   = 48'sh800000000000;
        c.int_max   = 48'sh7FFFFFFFFFFF;
        c.enables   = 5'b00001;
        return c;
    endfunction

    function automatic step_result_t predict_step(input logic m,
                                                  input logic signed [15:0] e,
                                                  input logic [15:0] dt);
        step_result_t r;
        logic [47:0]  g;
        longint       ev, dtv, kp, ki, kd, diff, s, integ, dterm, acc, v;
        r = '0;
        ev = longint'(e);
        dtv = longint'(dt);
        integ = 0;
        dterm = 0;
        if (m)
        begin
            integ_acc = 0;
            last_err  = '0;
            return r;
        end
        g = (ev >= 0) ? cur_cfg.gains_pos : cur_cfg.gains_neg;
        kp = longint'($signed(g[15:0]));
        ki = longint'($signed(g[31:16]));
        kd = longint'($signed(g[47:32]));
        diff = have_last ? ev - longint'(last_err) : 0;
        have_last = 1'b1;
        last_err  = e;

        // integration needs both ki values positive, whichever set is in use
        if (cur_cfg.enables[EN_INT] && $signed(cur_cfg.gains_pos[31:16]) > 0
                && $signed(cur_cfg.gains_neg[31:16]) > 0)
        begin
            s = integ_acc + ki * ev * dtv;
            if (s > INTEG_MAX_V)
            begin
                s = INTEG_MAX_V;
                r.int_clamped = 1'b1;
            end
            else if (s < INTEG_MIN_V)
            begin
                s = INTEG_MIN_V;
                r.int_clamped = 1'b1;
            end
            if (cur_cfg.enables[EN_INT_MAX] && s > longint'(cur_cfg.int_max))
            begin
                s = longint'(cur_cfg.int_max);
                r.int_clamped = 1'b1;
            end
            else if (cur_cfg.enables[EN_INT_MIN] && s < longint'(cur_cfg.int_min))
            begin
                s = longint'(cur_cfg.int_min);
                r.int_clamped = 1'b1;
            end
            integ_acc = s;
            integ = s;
        end

        if (dtv != 0)
            dterm = (kd * diff) / dtv;   // truncates toward zero

        acc = kp * ev + integ + dterm;
        v = (acc * longint'(cur_cfg.scale)) >>> 8;   // floor
        if (v > DRIVE_MAX_V)
        begin
            v = DRIVE_MAX_V;
            r.out_clamped = 1'b1;
        end
        else if (v < DRIVE_MIN_V)
        begin
            v = DRIVE_MIN_V;
            r.out_clamped = 1'b1;
        end
        if (cur_cfg.enables[EN_OUT_MAX] && v > longint'(cur_cfg.out_max))
        begin
            v = longint'(cur_cfg.out_max);
            r.out_clamped = 1'b1;
        end
        else if (cur_cfg.enables[EN_OUT_MIN] && v < longint'(cur_cfg.out_min))
        begin
            v = longint'(cur_cfg.out_min);
            r.out_clamped = 1'b1;
        end
        r.drive = v[31:0];
        return r;
    endfunction

    // one command transfer, with an optional idle burst ahead of it
    task automatic send_step(input logic m, input logic signed [15:0] e,
                             input logic [15:0] dt);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.mode     <= m;
        cmd_ch.error_in <= e;
        cmd_ch.step_ms  <= dt;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        pending_drive.push_back(predict_step(m, e, dt));
    endtask

    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
    endtask

    // upper bits beyond the register width carry junk; the block must drop them
    task automatic put_reg(input cfg_reg_t idx, input logic [47:0] value, input int w);
        logic [47:0] mask;
        logic [47:0] junk;
        mask = (48'd1 << w) - 48'd1;
        junk = 48'({$urandom, $urandom});
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (junk & ~mask) | (value & mask);
        @(posedge clk);
    endtask

    task automatic apply_config(input ctl_cfg_t c);
        wait_idle();
        put_reg(CFG_GAINS_POS, c.gains_pos, 48);
        put_reg(CFG_GAINS_NEG, c.gains_neg, 48);
        put_reg(CFG_SCALE, 48'(c.scale), 16);
        put_reg(CFG_OUT_MIN, 48'(c.out_min), 32);
        put_reg(CFG_OUT_MAX, 48'(c.out_max), 32);
        put_reg(CFG_INT_MIN, c.int_min, 48);
        put_reg(CFG_INT_MAX, c.int_max, 48);
        put_reg(CFG_ENABLES, 48'(c.enables), 5);
        cfg_we  <= 1'b0;
        cur_cfg = c;
    endtask

    function automatic logic [47:0] pack_gains(input logic [15:0] kp,
                                               input logic [15:0] ki,
                                               input logic [15:0] kd);
        return {kd, ki, kp};
    endfunction

    function automatic logic [15:0] small_gain(input int lo, input int hi);
        int v;
        v = $urandom_range(0, hi - lo) + lo;
        return v[15:0];
    endfunction

    function automatic ctl_cfg_t make_cfg(input int style);
        ctl_cfg_t c;
        c = reset_cfg();
        case (style)
            STYLE_TYPICAL:
            begin
                c.gains_pos = pack_gains(small_gain(-2048, 2048), small_gain(1, 512),
                                         small_gain(-2048, 2048));
                c.gains_neg = pack_gains(small_gain(-2048, 2048), small_gain(1, 512),
                                         small_gain(-2048, 2048));
                c.scale     = small_gain(-512, 512);
                c.out_min   = -($signed($urandom) >>> $urandom_range(1, 16));
                c.out_max   = $signed($urandom) >>> $urandom_range(1, 16);
                c.int_min   = 48'(longint'($signed($urandom)) <<< $urandom_range(0, 12));
                c.int_max   = 48'(longint'($signed($urandom)) <<< $urandom_range(0, 12));
                c.enables   = {4'($urandom_range(0, 15)), 1'b1};
            end
            STYLE_MAX:
            begin
                c.gains_pos = {3{16'h7FFF}};
                c.gains_neg = {3{16'h7FFF}};
                c.scale     = 16'sh7FFF;
                c.enables   = 5'b11111;
            end
            STYLE_MIN:
            begin
                c.gains_pos = {3{16'h8000}};
                c.gains_neg = {3{16'h8000}};
                c.scale     = 16'sh8000;
                c.out_min   = 32'sh7FFFFFFF;
                c.out_max   = 32'sh80000000;
                c.int_min   = 48'sh7FFFFFFFFFFF;
                c.int_max   = 48'sh800000000000;
                c.enables   = 5'b00000;
            end
            STYLE_NO_OUT:
            begin
                c.gains_pos = 48'({$urandom, $urandom});
                c.gains_neg = 48'({$urandom, $urandom});
                c.scale     = '0;
                c.enables   = 5'b11111;
            end
            default:
            begin
                c.gains_pos = 48'({$urandom, $urandom});
                c.gains_neg = 48'({$urandom, $urandom});
                c.scale     = 16'($urandom);
                c.out_min   = $urandom;
                c.out_max   = $urandom;
                c.int_min   = 48'({$urandom, $urandom});
                c.int_max   = 48'({$urandom, $urandom});
                c.enables   = 5'($urandom);
            end
        endcase
        return c;
    endfunction

    function automatic logic signed [15:0] rand_error();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return 16'($urandom);
        else if (pick < 8)
            return small_gain(-512, 512);
        else if (pick == 8)
            return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        else
            return '0;
    endfunction

    function automatic logic [15:0] rand_step_ms();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick < 6)
            return 16'($urandom_range(1, 100));
        else if (pick < 9)
            return 16'($urandom);
        else
            return 16'hFFFF;
    endfunction

    // result side: random backpressure, compare against the oldest prediction
    always @(posedge clk)
    begin
        step_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_drive.size() == 0)
            begin
                $display("%0t: unexpected result: drive %0d out_clamped %0b int_clamped %0b",
                         $time, rsp_ch.drive, rsp_ch.out_clamped, rsp_ch.int_clamped);
                err_count++;
            end
            else
            begin
                want = pending_drive.pop_front();
                if (rsp_ch.drive !== want.drive)
                begin
                    $display("%0t: drive mismatch: expected %0d actual %0d",
                             $time, want.drive, rsp_ch.drive);
                    err_count++;
                end
                if (rsp_ch.out_clamped !== want.out_clamped)
                begin
                    $display("%0t: out_clamped mismatch: expected %0b actual %0b",
                             $time, want.out_clamped, rsp_ch.out_clamped);
                    err_count++;
                end
                if (rsp_ch.int_clamped !== want.int_clamped)
                begin
                    $display("%0t: int_clamped mismatch: expected %0b actual %0b",
                             $time, want.int_clamped, rsp_ch.int_clamped);
                    err_count++;
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            stall_left = $urandom_range(0, 11);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        // kp = 256, scale = 1.0, ki = 0 at reset, so the integral stays out
        send_step(1'b0, 16'sd0, 16'd10);
        send_step(1'b0, 16'sh7FFF, 16'hFFFF);
        send_step(1'b0, 16'sh8000, 16'd0);
        send_step(1'b1, 16'sd1234, 16'd5);
        send_step(1'b0, -16'sd1, 16'd1);
    endtask

    task automatic test_integral_and_limits();
        ctl_cfg_t c;
        c = reset_cfg();
        c.gains_pos = pack_gains(16'h0100, 16'h0080, 16'h0200);
        c.gains_neg = pack_gains(16'h0180, 16'h0040, 16'h7FFF);
        c.out_min   = -32'sh01000000;
        c.out_max   = 32'sh01000000;
        c.int_min   = -(48'sd1 <<< 40);
        c.int_max   = 48'sd1 <<< 40;
        c.enables   = 5'b11111;
        apply_config(c);
        repeat (3) send_step(1'b0, 16'sh7FFF, 16'hFFFF);
        send_step(1'b0, 16'sh8000, 16'hFFFF);
        send_step(1'b0, 16'sh8000, 16'd1);
        send_step(1'b0, 16'sd0, 16'd0);
        // a clear keeps the first-step flag, so the next derivative is taken from 0
        send_step(1'b1, 16'sh7FFF, 16'hFFFF);
        send_step(1'b0, 16'sd100, 16'd3);
    endtask

    task automatic test_saturation();
        ctl_cfg_t c;
        c = reset_cfg();
        c.gains_pos = {3{16'h7FFF}};
        c.gains_neg = {3{16'h7FFF}};
        c.scale     = 16'sh7FFF;
        c.enables   = 5'b00001;
        apply_config(c);
        repeat (3) send_step(1'b0, 16'sh7FFF, 16'hFFFF);
        send_step(1'b0, 16'sh8000, 16'hFFFF);
    endtask

    task automatic test_crossed_limits();
        ctl_cfg_t c;
        c = reset_cfg();
        c.gains_pos = pack_gains(16'h4000, 16'h0100, 16'h0000);
        c.gains_neg = pack_gains(16'h4000, 16'hFF00, 16'h0000);  // negative ki: no integral
        c.out_min   = 32'sd1000;
        c.out_max   = -32'sd1000;
        c.enables   = 5'b00111;
        apply_config(c);
        send_step(1'b0, 16'sd5, 16'd1);
        send_step(1'b0, -16'sd5, 16'd1);
        send_step(1'b0, 16'sd0, 16'd2);
    endtask

    task automatic test_random_steps();
        int styles[RAND_PHASES] = '{STYLE_TYPICAL, STYLE_MAX, STYLE_TYPICAL, STYLE_MIN,
                                    STYLE_ANY, STYLE_NO_OUT, STYLE_ANY, STYLE_TYPICAL,
                                    STYLE_ANY, STYLE_TYPICAL};
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            apply_config(make_cfg(styles[p]));
            if (p == RAND_PHASES - 1)
                gaps_on = 1'b0;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_step($urandom_range(0, 31) == 0, rand_error(), rand_step_ms());
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.mode     = 1'b0;
        cmd_ch.error_in = '0;
        cmd_ch.step_ms  = '0;
        rsp_ch.ready    = 1'b0;
        err_count       = 0;
        gaps_on         = 1'b1;
        stall_left      = 0;
        quiet_cycles    = 0;
        cur_cfg         = reset_cfg();
        integ_acc       = 0;
        last_err        = '0;
        have_last       = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_integral_and_limits();
        test_saturation();
        test_crossed_limits();
        test_random_steps();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
